>>> src/lwe_pkg.sv
// Package with shared types, constants and the log2 table of the entropy unit.
package lwe_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned LOG_W   = 27;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [LOG_W-1:0] log_tab_t [256];

  typedef struct packed {
    logic start;
    logic write;
    logic frd;
    logic hrd;
    logic hwr;
    logic logn;
    logic muln;
    logic scan;
    logic sub;
    logic div;
    logic load;
  } lwe_cmd_t;

  typedef struct packed {
    logic bad;
    logic pix_last;
    logic scan_last;
    logic pipe_empty;
    logic div_last;
    logic out_busy;
  } lwe_sts_t;

  // log2(v) in Q.24; the fraction comes from repeated squaring of the mantissa.
  function automatic log_tab_t gen_log_tab();
    log_tab_t t;
    logic [63:0] m;
    logic [23:0] frac;
    int unsigned e;
    for (int v = 0; v < 256; v++) begin
      if (v == 0) begin
        t[v] = '0;
      end else begin
        e = 0;
        for (int k = 1; k < 8; k++) begin
          if ((v >> k) != 0) e = k;
        end
        m = (64'(v) << 30) >> e;
        frac = '0;
        for (int i = 0; i < 24; i++) begin
          m = (m * m) >> 30;
          frac = {frac[22:0], 1'b0};
          if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac[0] = 1'b1;
          end
        end
        t[v] = {3'(e), frac};
      end
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = gen_log_tab();

endpackage

>>> src/lwe_if.sv
// Valid/ready channel interfaces for query input and entropy result.
interface lwe_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] pixel;
  modport source (output valid, func, x, y, pixel, input ready);
  modport sink   (input valid, func, x, y, pixel, output ready);
endinterface

interface lwe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entropy_q12;
  logic [7:0]  pixels_counted;
  logic        bad_coordinate;
  modport source (output valid, entropy_q12, pixels_counted, bad_coordinate, input ready);
  modport sink   (input valid, entropy_q12, pixels_counted, bad_coordinate, output ready);
endinterface

>>> src/lwe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lwe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/lwe_ctrl.sv
// Controller state machine that sequences histogram build, scan and division.
module lwe_ctrl import lwe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_ready_o,
  input  lwe_sts_t sts_i,
  output lwe_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FWT, S_HWT, S_LOGN, S_MULN, S_SCAN, S_DRAIN, S_SUB, S_DIV, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_QUERY) begin
            cmd_o.start = 1'b1;
            state_d = sts_i.bad ? S_DONE : S_FRD;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      S_FRD: begin
        cmd_o.frd = 1'b1;
        state_d = S_FWT;
      end
      S_FWT: begin
        cmd_o.hrd = 1'b1;
        state_d = S_HWT;
      end
      S_HWT: begin
        cmd_o.hwr = 1'b1;
        state_d = sts_i.pix_last ? S_LOGN : S_FRD;
      end
      S_LOGN: begin
        cmd_o.logn = 1'b1;
        state_d = S_MULN;
      end
      S_MULN: begin
        cmd_o.muln = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) state_d = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> src/lwe_datapath.sv
// Datapath: configuration, frame store, histogram, log sums and divider.
module lwe_datapath import lwe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            in_x_i,
  input  logic [7:0]            in_y_i,
  input  logic [7:0]            in_pixel_i,
  input  lwe_cmd_t              cmd_i,
  output lwe_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [Q_W-1:0]        out_entropy_o,
  output logic [CNT_W-1:0]      out_count_o,
  output logic                  out_bad_o
);
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [8:0] fw_q, fh_q;
  logic [3:0] ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 9'd256;
      fh_q <= 9'd256;
      ws_q <= 4'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        CFG_WINDOW_SIZE:  ws_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, window half and clipped bounds of the query.
  logic [COORD_W-1:0] w, h, xi, yi, half, xsum, ysum, xs, xe, ys, ye;
  logic [3:0]         ws;
  logic               in_frame;

  always_comb begin
    w  = (32'(fw_q) > MAX_WIDTH)  ? COORD_W'(MAX_WIDTH)  : COORD_W'(fw_q);
    h  = (32'(fh_q) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(fh_q);
    ws = (32'(ws_q) > MAX_WINDOW) ? 4'(MAX_WINDOW) : ws_q;
    half = COORD_W'(ws[3:1]);
    xi = COORD_W'(in_x_i);
    yi = COORD_W'(in_y_i);
    in_frame = (xi < w) && (yi < h);
    xs = (xi >= half) ? xi - half : '0;
    ys = (yi >= half) ? yi - half : '0;
    xsum = xi + half;
    ysum = yi + half;
    xe = (xsum >= w) ? w - 1'b1 : xsum;
    ye = (ysum >= h) ? h - 1'b1 : ysum;
  end

  logic [COORD_W-1:0] xs_q, xe_q, ye_q, px_q, py_q;
  logic               bad_q;
  logic [CNT_W-1:0]   n_q;
  logic               pix_last;

  assign pix_last = (px_q == xe_q) && (py_q == ye_q);

  // Frame store.
  logic [ADDR_W-1:0] f_waddr, f_raddr;
  logic [7:0]        f_rdata;
  logic              f_we;

  assign f_we    = cmd_i.write && in_frame;
  assign f_waddr = ADDR_W'(yi) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xi);
  assign f_raddr = ADDR_W'(py_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(px_q);

  lwe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (in_pixel_i),
    .re_i    (cmd_i.frd),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // Histogram; a bin whose valid bit is clear reads as zero.
  logic [255:0]     hvalid_q;
  logic [7:0]       bin_q, b_q, h_raddr;
  logic [CNT_W-1:0] h_rdata, h_old;

  assign h_raddr = cmd_i.scan ? b_q : f_rdata;
  assign h_old   = hvalid_q[bin_q] ? h_rdata : '0;

  lwe_ram #(.WIDTH(CNT_W), .DEPTH(256)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hwr),
    .waddr_i (bin_q),
    .wdata_i (h_old + 1'b1),
    .re_i    (cmd_i.hrd || cmd_i.scan),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Scan pipeline: read bin, look up log, multiply, accumulate.
  logic               p1_q, p2_q, p3_q, hv1_q;
  logic [CNT_W-1:0]   c2_q;
  logic [LOG_W-1:0]   lg2_q, lg_q;
  logic [SUM_W-1:0]   prod_q, sum_q, tot_q, rem_q, dsr_q, diff;
  logic [CNT_W-1:0]   c1;
  logic [Q_W-1:0]     quot_q;
  logic [3:0]         dcnt_q;
  logic               out_valid_q;
  logic [Q_W-1:0]     out_e_q;
  logic [CNT_W-1:0]   out_n_q;
  logic               out_b_q;

  assign c1   = hv1_q ? h_rdata : '0;
  assign diff = (tot_q > sum_q) ? tot_q - sum_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q    <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      p3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) hvalid_q <= '0;
      else if (cmd_i.hwr) hvalid_q[bin_q] <= 1'b1;
      p1_q <= cmd_i.scan;
      p2_q <= p1_q;
      p3_q <= p2_q;
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bad_q  <= !in_frame;
      xs_q   <= xs;
      xe_q   <= xe;
      ye_q   <= ye;
      px_q   <= xs;
      py_q   <= ys;
      n_q    <= '0;
      b_q    <= '0;
      sum_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.hrd) bin_q <= f_rdata;
    if (cmd_i.hwr) begin
      n_q <= n_q + 1'b1;
      if (px_q == xe_q) begin
        px_q <= xs_q;
        py_q <= py_q + 1'b1;
      end else begin
        px_q <= px_q + 1'b1;
      end
    end
    if (cmd_i.logn) lg_q <= LOG_TAB[n_q];
    if (cmd_i.muln) tot_q <= SUM_W'(n_q) * SUM_W'(lg_q);
    if (cmd_i.scan) begin
      hv1_q <= hvalid_q[b_q];
      b_q   <= b_q + 1'b1;
    end
    if (p1_q) begin
      c2_q  <= c1;
      lg2_q <= LOG_TAB[c1];
    end
    if (p2_q) prod_q <= SUM_W'(c2_q) * SUM_W'(lg2_q);
    if (p3_q) sum_q <= sum_q + prod_q;
    if (cmd_i.sub) begin
      rem_q  <= diff + SUM_W'({n_q, 11'b0});
      dsr_q  <= SUM_W'({n_q, 27'b0});
      dcnt_q <= '0;
    end
    if (cmd_i.div) begin
      if (rem_q >= dsr_q) begin
        rem_q  <= rem_q - dsr_q;
        quot_q <= {quot_q[Q_W-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[Q_W-2:0], 1'b0};
      end
      dsr_q  <= dsr_q >> 1;
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.load) begin
      out_e_q <= quot_q;
      out_n_q <= n_q;
      out_b_q <= bad_q;
    end
  end

  assign sts_o.bad        = !in_frame;
  assign sts_o.pix_last   = pix_last;
  assign sts_o.scan_last  = (b_q == 8'hFF);
  assign sts_o.pipe_empty = !p1_q && !p2_q && !p3_q;
  assign sts_o.div_last   = (dcnt_q == 4'hF);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_entropy_o = out_e_q;
  assign out_count_o   = out_n_q;
  assign out_bad_o     = out_b_q;
endmodule

>>> src/local_window_entropy_unit.sv
// Top level of the local window entropy unit.
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      func, x, y, pixel
//   out_ch    out  valid/ready      entropy_q12, pixels_counted, bad_coordinate
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
// A query walks the n window pixels through the frame store and histogram
// read-modify-write, then a 256-bin histogram scan and a restoring divider.
// Reset clears the controller, histogram valid bits and output flag; the frame
// store is not cleared. A finished result waits in the output register while
// the next item is taken; a query finishing before it is taken waits for it.
module local_window_entropy_unit import lwe_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lwe_in_if.sink                in_ch,
  lwe_out_if.source             out_ch
);
  lwe_cmd_t cmd;
  lwe_sts_t sts;

  lwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_func_i  (in_ch.func),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lwe_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_x_i        (in_ch.x),
    .in_y_i        (in_ch.y),
    .in_pixel_i    (in_ch.pixel),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_entropy_o (out_ch.entropy_q12),
    .out_count_o   (out_ch.pixels_counted),
    .out_bad_o     (out_ch.bad_coordinate)
  );
endmodule
